// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/mom_pkg.sv =====
// Package with shared types and constants for the median-of-medians pivot block.
`timescale 1ns / 1ps
package mom_pkg;
  localparam int unsigned GROUP_SIZE = 5;
  localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_elem;   // write the input word at the fill count
    logic clear_list;   // reset fill count and overflow flag
    logic start_level;  // begin a grouping pass
    logic load_step;    // read/collect one word of the current group
    logic close_group;  // write the group median
    logic end_level;    // swap to medians as the source
    logic final_pick;   // latch the pivot from the collected group
  } mom_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic src_done;     // all words of the level have been requested
    logic group_full;   // group holds five words or source is exhausted
    logic level_small;  // current source has five words or fewer
  } mom_sts_t;
endpackage

// ===== src/mom_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
`timescale 1ns / 1ps
interface mom_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        last_item;
  modport source (output valid, value, last_item, input ready);
  modport sink (input valid, value, last_item, output ready);
endinterface

interface mom_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pivot;
  logic [10:0] item_count;
  logic        overflow;
  modport source (output valid, pivot, item_count, overflow, input ready);
  modport sink (input valid, pivot, item_count, overflow, output ready);
endinterface

// ===== src/mom_datapath.sv =====
// Datapath: element and median memories, group collector, sorter and counters.
`timescale 1ns / 1ps
module mom_datapath import mom_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mom_cmd_t    cmd,
  output mom_sts_t    sts,
  input  logic [31:0] in_word,
  output logic [31:0] pivot,
  output logic [10:0] count_out,
  output logic        ovf_out
);
  localparam int unsigned MED_DEPTH = (MAX_ITEMS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EA = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned MA = (MED_DEPTH > 1) ? $clog2(MED_DEPTH) : 1;

  logic [31:0] elem_mem [MAX_ITEMS];
  logic [31:0] med_mem [MED_DEPTH];

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          from_med_r;     // level source is the median memory
  logic [CW-1:0] len_r;          // words in the current level
  logic [CW-1:0] rd_idx_r;       // next word to request
  logic [CW-1:0] wr_idx_r;       // next median slot
  logic          rd_pend_r;      // a read was issued last cycle
  logic [31:0]   e_rd_r, m_rd_r;
  logic [31:0]   grp_r [GROUP_SIZE];
  logic [2:0]    gcnt_r;         // words collected in the group
  logic [2:0]    greq_r;         // words requested in the group
  logic [31:0]   pivot_r;

  logic [31:0] rd_word;
  logic [31:0] sorted [GROUP_SIZE];
  logic [31:0] med_word;

  assign rd_word = from_med_r ? m_rd_r : e_rd_r;

  // Fill count and overflow tracking.
  always_comb begin
    count_nxt = count_r;
    ovf_nxt = ovf_r;
    if (cmd.clear_list) begin
      count_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.store_elem) begin
      if (count_r < CW'(MAX_ITEMS)) count_nxt = count_r + 1'b1;
      else ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Element memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.store_elem && count_r < CW'(MAX_ITEMS))
      elem_mem[count_r[EA-1:0]] <= in_word ^ SIGN_BIAS;
    e_rd_r <= elem_mem[rd_idx_r[EA-1:0]];
  end

  // Median memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.close_group) med_mem[wr_idx_r[MA-1:0]] <= med_word;
    m_rd_r <= med_mem[rd_idx_r[MA-1:0]];
  end

  // Odd-even transposition sort of the collected group, unused slots at top.
  always_comb begin
    logic [31:0] t;
    t = '0;
    for (int k = 0; k < GROUP_SIZE; k++)
      sorted[k] = (3'(k) < gcnt_r) ? grp_r[k] : 32'hFFFF_FFFF;
    for (int p = 0; p < GROUP_SIZE; p++) begin
      for (int k = p % 2; k + 1 < GROUP_SIZE; k += 2) begin
        if (sorted[k] > sorted[k+1]) begin
          t = sorted[k];
          sorted[k] = sorted[k+1];
          sorted[k+1] = t;
        end
      end
    end
    med_word = sorted[gcnt_r >> 1];
  end

  // Level sequencing, reads and group collection.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_med_r <= 1'b0;
      rd_pend_r <= 1'b0;
      gcnt_r <= '0;
      greq_r <= '0;
    end else begin
      rd_pend_r <= cmd.load_step && !sts.group_full && greq_r < 3'(GROUP_SIZE)
                   && rd_idx_r < len_r;
      if (rd_pend_r) begin
        grp_r[gcnt_r] <= rd_word;
        gcnt_r <= gcnt_r + 1'b1;
      end
      if (cmd.start_level) begin
        if (!from_med_r) len_r <= count_r;
        rd_idx_r <= '0;
        wr_idx_r <= '0;
        gcnt_r <= '0;
        greq_r <= '0;
      end else if (cmd.load_step && greq_r < 3'(GROUP_SIZE) && rd_idx_r < len_r) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        greq_r <= greq_r + 1'b1;
      end
      if (cmd.close_group) begin
        wr_idx_r <= wr_idx_r + 1'b1;
        gcnt_r <= '0;
        greq_r <= '0;
      end
      if (cmd.end_level) begin
        from_med_r <= 1'b1;
        len_r <= wr_idx_r;
      end
      if (cmd.final_pick) begin
        pivot_r <= med_word ^ SIGN_BIAS;
        from_med_r <= 1'b0;
      end
    end
  end

  // Group is complete once all requested words have arrived.
  assign sts.group_full = !rd_pend_r && (greq_r == 3'(GROUP_SIZE) || rd_idx_r >= len_r)
                          && gcnt_r == greq_r && gcnt_r != 3'd0;
  assign sts.src_done = rd_idx_r >= len_r && !rd_pend_r;
  assign sts.level_small = len_r <= CW'(GROUP_SIZE);

  assign pivot = pivot_r;
  assign count_out = 11'(count_r);
  assign ovf_out = ovf_r;
endmodule

// ===== src/mom_ctrl.sv =====
// Controller state machine sequencing load, grouping levels and result.
`timescale 1ns / 1ps
module mom_ctrl import mom_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     in_last,
  input  logic     out_valid,
  input  logic     out_fire,
  input  mom_sts_t sts,
  output mom_cmd_t cmd,
  output logic     load_ready,
  output logic     res_load
);
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_GRP   = 3'd2;
  localparam logic [2:0] S_LEVEL = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       first_r, first_nxt;  // first level reads the element memory

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd = '0;
    res_load = 1'b0;
    load_ready = (state_r == S_LOAD);
    unique case (state_r)
      S_LOAD: begin
        cmd.store_elem = in_fire;
        if (in_fire && in_last) begin
          state_nxt = S_START;
          first_nxt = 1'b1;
        end
      end
      S_START: begin
        // First level always groups; later levels stop once five or fewer remain.
        if (!first_r && sts.level_small) begin
          cmd.start_level = 1'b1;
          state_nxt = S_FINAL;
        end else begin
          cmd.start_level = 1'b1;
          state_nxt = S_GRP;
        end
        first_nxt = 1'b0;
      end
      S_GRP: begin
        cmd.load_step = 1'b1;
        if (sts.group_full) begin
          cmd.load_step = 1'b0;
          cmd.close_group = 1'b1;
          if (sts.src_done) state_nxt = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.end_level = 1'b1;
        state_nxt = S_START;
      end
      S_FINAL: begin
        cmd.load_step = 1'b1;
        if (sts.group_full) begin
          cmd.load_step = 1'b0;
          cmd.final_pick = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_fire) begin
          res_load = 1'b1;
          cmd.clear_list = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end
endmodule

// ===== src/median_of_medians_pivot.sv =====
// Top level of the median-of-medians pivot block.
//
// Usage: list elements arrive as input transactions on in_ch, one signed
// word each; the transaction with last_item set closes the list. Up to
// MAX_ITEMS elements are stored; later ones are dropped and flagged.
// After the last element the block groups the list in fives, keeps each
// group median in a second memory and repeats on the medians until five
// or fewer remain, then picks their median as the pivot. One result
// transaction on out_ch carries pivot, item_count and overflow.
// Input is not taken while a list is computed; while loading, each
// element is stored as it is taken. A group of five is read through the
// single read port of the source memory: five reads, then a wait for the
// last read to land, then the write of the median. The result waits in
// an output register while the receiver stalls; loading of the next
// list resumes as soon as the result is placed there. Synchronous reset
// clears the fill count, the overflow flag and the controller; the
// memories need no clearing.
`timescale 1ns / 1ps
module median_of_medians_pivot import mom_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input logic clk,
  input logic rst_n,
  mom_in_if.sink    in_ch,
  mom_out_if.source out_ch
);
  mom_cmd_t    cmd;
  mom_sts_t    sts;
  logic        load_ready, res_load;
  logic [31:0] pivot;
  logic [10:0] cnt;
  logic        ovf;
  logic        out_valid_r;
  logic [31:0] out_pivot_r;
  logic [10:0] out_count_r;
  logic        out_ovf_r;

  assign in_ch.ready = load_ready;

  mom_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_ch.valid && load_ready), .in_last(in_ch.last_item),
    .out_valid(out_valid_r), .out_fire(out_valid_r && out_ch.ready),
    .sts(sts), .cmd(cmd), .load_ready(load_ready), .res_load(res_load)
  );

  mom_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_word(in_ch.value),
    .pivot(pivot), .count_out(cnt), .ovf_out(ovf)
  );

  // Output register holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_pivot_r <= pivot;
      out_count_r <= cnt;
      out_ovf_r <= ovf;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pivot = out_pivot_r;
  assign out_ch.item_count = out_count_r;
  assign out_ch.overflow = out_ovf_r;
endmodule

// ===== src/mom_checker.sv =====
// Port-level checker for the median-of-medians pivot block, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mom_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pivot,
  input logic [10:0] out_count
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pivot))
  `CHK_NEXT(a_busy_after_last, clk, rst_n, in_valid && in_ready && in_last, !in_ready)
  `CHK_IMPLY(a_count_nonzero, clk, rst_n, out_valid, out_count != 11'd0)
endmodule

bind median_of_medians_pivot mom_checker u_mom_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last_item),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_pivot(out_ch.pivot), .out_count(out_ch.item_count)
);
